@@ rtl/core/apd_pkg.sv @@
// shared types and constants for the aligned packet deframer
// no dependencies
package apd_pkg;

   localparam logic [15:0] MAGIC_RESET  = 16'h4153;
   localparam logic [12:0] BUFFER_BYTES = 13'd6144;
   localparam logic [12:0] POS_MAX      = 13'h1FFF;
   localparam logic [2:0]  HDR_LAST     = 3'd7;
   localparam logic [2:0]  HDR_MAGIC_HI = 3'd1;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_EMPTY   = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   localparam logic [1:0] TYPE_CONTROL = 2'd0;
   localparam logic [1:0] TYPE_NETWORK = 2'd1;
   localparam logic [1:0] TYPE_SERIAL  = 2'd2;

   localparam logic [15:0] FLAG_CONTROL = 16'd0;
   localparam logic [15:0] FLAG_NETWORK = 16'd2;
   localparam logic [15:0] FLAG_SERIAL  = 16'd3;

   localparam logic [1:0] STATUS_CLEAN     = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
   localparam logic [1:0] STATUS_OVERRUN   = 2'd2;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

   typedef enum logic [1:0] {
      PHASE_HEADER,
      PHASE_PAYLOAD,
      PHASE_PAD,
      PHASE_STOP
   } apd_phase_type;

   typedef struct packed {
      logic [7:0]  rx_byte;
      logic [12:0] buffer_length;
      logic        last_byte;
   } apd_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  payload_byte;
      logic [1:0]  packet_type;
      logic [15:0] channel_word;
      logic [12:0] payload_length;
      logic        packet_end;
      logic [1:0]  buffer_status;
   } apd_rsp_type;

   // everything one byte causes: an optional packet word and an optional buffer end
   typedef struct packed {
      logic        has_data;
      apd_rsp_type data;
      logic        has_end;
      logic [1:0]  end_status;
   } apd_entry_type;

endpackage

@@ rtl/core/aligned_packet_deframer.sv @@
// top level of the aligned packet deframer: parser, entry queue, result unpacker
// depends on apd_pkg, apd_front, apd_queue, apd_back
// a byte's queue entry is registered, then shows on rsp_data once the words ahead of it are popped
// throughput: one byte per cycle while req_full is low; a last byte that also carries a packet word gives two words
// queue of QUEUE_DEPTH entries between parser and unpacker sets how long output may stall
// reset: synchronous, clears parse state and queue, magic returns to 16'h4153
module aligned_packet_deframer import apd_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  apd_req_type req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output apd_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic          q_wr_en;
   apd_entry_type q_wr_data;
   logic          q_rd_en;
   apd_entry_type q_head;
   logic          q_empty;
   logic          q_full;

   assign csr_ready = 1'b1;

   apd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_wr_en   (q_wr_en),
      .q_wr_data (q_wr_data)
   );

   apd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_wr_en),
      .wr_data (q_wr_data),
      .rd_en   (q_rd_en),
      .rd_data (q_head),
      .empty   (q_empty),
      .full    (q_full)
   );

   apd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_rd_en   (q_rd_en),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

endmodule

@@ rtl/core/apd_front.sv @@
// header parser: accepts one byte a cycle while the queue is not full and classifies it into a queue entry
// depends on apd_pkg
module apd_front import apd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   input  apd_req_type   req_data,
   output logic          req_full,
   input  logic          csr_valid,
   input  logic [15:0]   csr_data,
   input  logic          q_full,
   output logic          q_wr_en,
   output apd_entry_type q_wr_data
);

   apd_phase_type phase_ff, phase_in, step_phase;
   logic [12:0]   pos_ff, pos_in, pos_next;
   logic [2:0]    hcount_ff, hcount_in, step_hcount;
   logic [63:0]   hdr_ff, hdr_in;
   logic [12:0]   rem_ff, rem_in, step_rem;
   logic [2:0]    pad_ff, pad_in, step_pad;
   logic [1:0]    stop_ff, stop_in, step_stop;
   logic [15:0]   magic_ff;

   logic          accept;
   logic [7:0]    b;
   logic [12:0]   blen;
   logic [15:0]   len16;
   logic [15:0]   chan_now;
   logic [15:0]   flag;
   logic          skip;
   logic [1:0]    ptype;
   logic          magic_bad;
   logic          hdr_done;
   logic          overrun;
   logic [2:0]    pad_calc;
   apd_entry_type entry;

   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign b         = req_data.rx_byte;
   assign blen      = (req_data.buffer_length > BUFFER_BYTES) ? BUFFER_BYTES
                                                              : req_data.buffer_length;
   assign pos_next  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 13'd1;
   assign len16     = hdr_ff[47:32];
   assign chan_now  = {b, hdr_ff[55:48]};
   assign flag      = hdr_ff[31:16];
   assign magic_bad = (hcount_ff == HDR_MAGIC_HI) && ({b, hdr_ff[7:0]} != magic_ff);
   assign hdr_done  = (hcount_ff == HDR_LAST);
   assign overrun   = ({4'd0, pos_next} + {1'b0, len16}) > {4'd0, blen};
   assign pad_calc  = 3'd0 - len16[2:0];

   always_comb begin
      unique case (flag)
         FLAG_CONTROL: begin ptype = TYPE_CONTROL; skip = 1'b0; end
         FLAG_NETWORK: begin ptype = TYPE_NETWORK; skip = 1'b0; end
         FLAG_SERIAL:  begin ptype = TYPE_SERIAL;  skip = 1'b0; end
         default:      begin ptype = TYPE_CONTROL; skip = 1'b1; end
      endcase
   end

   // next state
   always_comb begin
      step_phase  = phase_ff;
      step_hcount = hcount_ff;
      step_rem    = rem_ff;
      step_pad    = pad_ff;
      step_stop   = stop_ff;
      hdr_in      = hdr_ff;
      unique case (phase_ff)
         PHASE_HEADER: begin
            hdr_in[{hcount_ff, 3'b000} +: 8] = b;
            step_hcount = hcount_ff + 3'd1;
            if (magic_bad) begin
               step_phase = PHASE_STOP;
               step_stop  = STATUS_BAD_MAGIC;
            end else if (hdr_done) begin
               step_hcount = 3'd0;
               if (overrun) begin
                  step_phase = PHASE_STOP;
                  step_stop  = STATUS_OVERRUN;
               end else begin
                  step_pad = pad_calc;
                  step_rem = len16[12:0];
                  if (len16 != 16'd0) begin
                     step_phase = PHASE_PAYLOAD;
                  end else begin
                     step_phase = (pad_calc != 3'd0) ? PHASE_PAD : PHASE_HEADER;
                  end
               end
            end
         end
         PHASE_PAYLOAD: begin
            step_rem = rem_ff - 13'd1;
            if (rem_ff == 13'd1) begin
               step_phase = (pad_ff != 3'd0) ? PHASE_PAD : PHASE_HEADER;
            end
         end
         PHASE_PAD: begin
            step_pad = pad_ff - 3'd1;
            if (pad_ff == 3'd1) begin
               step_phase = PHASE_HEADER;
            end
         end
         PHASE_STOP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (!accept) begin
         phase_in  = phase_ff;
         pos_in    = pos_ff;
         hcount_in = hcount_ff;
         rem_in    = rem_ff;
         pad_in    = pad_ff;
         stop_in   = stop_ff;
      end else if (req_data.last_byte) begin
         phase_in  = PHASE_HEADER;
         pos_in    = 13'd0;
         hcount_in = 3'd0;
         rem_in    = 13'd0;
         pad_in    = 3'd0;
         stop_in   = STATUS_CLEAN;
      end else begin
         phase_in  = step_phase;
         pos_in    = pos_next;
         hcount_in = step_hcount;
         rem_in    = step_rem;
         pad_in    = step_pad;
         stop_in   = step_stop;
      end
   end

   // outputs
   always_comb begin
      entry                     = '0;
      entry.data.packet_type    = ptype;
      entry.data.channel_word   = hdr_ff[63:48];
      entry.data.payload_length = hdr_ff[44:32];
      if (phase_ff == PHASE_PAYLOAD && !skip) begin
         entry.has_data          = 1'b1;
         entry.data.result_kind  = KIND_PAYLOAD;
         entry.data.payload_byte = b;
         entry.data.packet_end   = (rem_ff == 13'd1);
      end else if (phase_ff == PHASE_HEADER && hdr_done && !overrun
                   && len16 == 16'd0 && !skip) begin
         entry.has_data            = 1'b1;
         entry.data.result_kind    = KIND_EMPTY;
         entry.data.channel_word   = chan_now;
         entry.data.payload_length = 13'd0;
         entry.data.packet_end     = 1'b1;
      end
      entry.has_end = req_data.last_byte;
      if (step_phase == PHASE_STOP) begin
         entry.end_status = step_stop;
      end else if (step_phase == PHASE_HEADER && step_hcount != 3'd0) begin
         entry.end_status = STATUS_TRUNCATED;
      end else if (step_phase == PHASE_PAYLOAD) begin
         entry.end_status = STATUS_OVERRUN;
      end else begin
         entry.end_status = STATUS_CLEAN;
      end
   end

   assign q_wr_en   = accept && (entry.has_data || entry.has_end);
   assign q_wr_data = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         pos_ff    <= 13'd0;
         hcount_ff <= 3'd0;
         rem_ff    <= 13'd0;
         pad_ff    <= 3'd0;
         stop_ff   <= STATUS_CLEAN;
         magic_ff  <= MAGIC_RESET;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         hcount_ff <= hcount_in;
         rem_ff    <= rem_in;
         pad_ff    <= pad_in;
         stop_ff   <= stop_in;
         if (csr_valid) begin
            magic_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && phase_ff == PHASE_HEADER) begin
         hdr_ff <= hdr_in;
      end
   end

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_PAYLOAD |-> rem_ff != 13'd0)
      else $error("payload phase with no bytes left");
   a_pad_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_PAD |-> pad_ff != 3'd0)
      else $error("pad phase with no pad left");
   a_buffer_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> phase_ff == PHASE_HEADER && pos_ff == 13'd0
                                       && hcount_ff == 3'd0)
      else $error("parse state not cleared after buffer end");

endmodule

@@ rtl/core/apd_queue.sv @@
// small register queue of parsed entries between parser and result unpacker
// depends on apd_pkg
module apd_queue import apd_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  apd_entry_type wr_data,
   input  logic          rd_en,
   output apd_entry_type rd_data,
   output logic          empty,
   output logic          full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   apd_entry_type          store_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_wr;
   logic                   do_rd;

   assign empty   = (count_ff == CNT_W'(0));
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      full && !rd_en |=> full)
      else $error("full queue drained without a read");

endmodule

@@ rtl/core/apd_back.sv @@
// result unpacker: turns each queue entry into one or two result words
// depends on apd_pkg
module apd_back import apd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  apd_entry_type q_head,
   input  logic          q_empty,
   output logic          q_rd_en,
   output apd_rsp_type   rsp_data,
   output logic          rsp_empty,
   input  logic          rsp_pop
);

   logic        data_done_ff, data_done_in;
   logic        show_data;
   logic        take;
   apd_rsp_type end_word;

   assign show_data = q_head.has_data && !data_done_ff;
   assign take      = rsp_pop && !q_empty;
   assign rsp_empty = q_empty;

   always_comb begin
      end_word               = '0;
      end_word.result_kind   = KIND_END;
      end_word.buffer_status = q_head.end_status;
   end

   assign rsp_data = show_data ? q_head.data : end_word;

   always_comb begin
      q_rd_en      = 1'b0;
      data_done_in = data_done_ff;
      if (take) begin
         if (show_data && q_head.has_end) begin
            data_done_in = 1'b1;
         end else begin
            q_rd_en      = 1'b1;
            data_done_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_done_ff <= 1'b0;
      end else begin
         data_done_ff <= data_done_in;
      end
   end

   a_split_entry: assert property (@(posedge clock) disable iff (reset)
      data_done_ff |-> !q_empty && q_head.has_data && q_head.has_end)
      else $error("second half pending without a split entry");
   a_split_end: assert property (@(posedge clock) disable iff (reset)
      data_done_ff && rsp_pop |-> q_rd_en && rsp_data.result_kind == KIND_END)
      else $error("split entry not finished by buffer end word");

endmodule
